FILE: hdl/ecr_pkg.sv
// shared types and constants for the elevation color ramp
`timescale 1ns / 1ps

package ecr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_ELEV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_ELEV   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BROWN_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE  = 3'd4;

    // quotient bits: eight level bits plus one overflow bit
    localparam int QUOT_W  = 9;
    localparam int LEVEL_W = 8;

    // how the level is spread over the three channels
    typedef enum logic [1:0] {
        CH_ALL,
        CH_BLUE,
        CH_GREEN,
        CH_BROWN
    } chan_t;

endpackage

FILE: hdl/ecr_prep.sv
// band selection and numerator / divisor setup, two pipeline stages
`timescale 1ns / 1ps

module ecr_prep #(
    parameter int SAMPLE_BITS = 16,
    parameter int NUM_W       = 29,
    parameter int DIV_W       = 21
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_elev,
    input  logic signed [SAMPLE_BITS-1:0] floor_elev,
    input  logic signed [SAMPLE_BITS-1:0] peak_elev,
    input  logic signed [SAMPLE_BITS-1:0] green_limit,
    input  logic signed [SAMPLE_BITS-1:0] brown_limit,
    input  logic                          color_mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NUM_W-1:0]              out_num,
    output logic [DIV_W-1:0]              out_div,
    output ecr_pkg::chan_t                out_chan
);
    import ecr_pkg::*;

    localparam int EW = SAMPLE_BITS + 2;
    localparam int MW = SAMPLE_BITS + 1;

    typedef enum logic [2:0] {
        KIND_GRAY,
        KIND_BLUE,
        KIND_GREEN,
        KIND_BROWN,
        KIND_TOP
    } kind_t;

    logic signed [EW-1:0] h_x, min_x, max_x, gl_x, bl_x;
    logic signed [EW-1:0] a_n_next, a_d_next;
    kind_t                a_kind_next;
    logic                 a_ready;

    logic                 a_valid_reg;
    kind_t                a_kind_reg;
    logic signed [EW-1:0] a_n_reg, a_d_reg;

    logic [MW-1:0]    n_m, d_m;
    logic             n_pos, d_pos, n_ge_d;
    logic [NUM_W-1:0] x_val, x255, num_next;
    logic [DIV_W-1:0] div_next;
    chan_t            chan_next;
    logic             b_ready;

    logic             b_valid_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DIV_W-1:0] div_reg;
    chan_t            chan_reg;

    assign h_x   = EW'(in_elev);
    assign min_x = EW'(floor_elev);
    assign max_x = EW'(peak_elev);
    assign gl_x  = EW'(green_limit);
    assign bl_x  = EW'(brown_limit);

    // bands are tested in order; the blue and top bands can be picked even when empty
    always_comb begin
        if (!color_mode) begin
            a_kind_next = KIND_GRAY;
            a_n_next    = h_x - min_x;
            a_d_next    = max_x - min_x;
        end else if (h_x[EW-1]) begin
            a_kind_next = KIND_BLUE;
            a_n_next    = h_x - min_x;
            a_d_next    = -min_x;
        end else if (h_x < gl_x) begin
            a_kind_next = KIND_GREEN;
            a_n_next    = h_x;
            a_d_next    = gl_x;
        end else if (h_x < bl_x) begin
            a_kind_next = KIND_BROWN;
            a_n_next    = h_x - gl_x;
            a_d_next    = bl_x - gl_x;
        end else begin
            a_kind_next = KIND_TOP;
            a_n_next    = h_x - bl_x;
            a_d_next    = max_x - bl_x;
        end
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
        if (a_ready && in_valid) begin
            a_kind_reg <= a_kind_next;
            a_n_reg    <= a_n_next;
            a_d_reg    <= a_d_next;
        end
    end

    // magnitudes are only used where the value is known non-negative
    assign n_m    = a_n_reg[MW-1:0];
    assign d_m    = a_d_reg[MW-1:0];
    assign n_pos  = !a_n_reg[EW-1] && (a_n_reg != '0);
    assign d_pos  = !a_d_reg[EW-1] && (a_d_reg != '0);
    assign n_ge_d = a_n_reg >= a_d_reg;

    always_comb begin
        unique case (a_kind_reg)
            KIND_GRAY, KIND_BLUE: x_val = NUM_W'(n_m);
            KIND_BROWN:           x_val = (NUM_W'(d_m) << 1) + (NUM_W'(n_m) << 2)
                                          + NUM_W'(n_m);
            default:              x_val = NUM_W'(n_m) + NUM_W'(d_m);
        endcase
    end

    // times 255 as shift and subtract
    assign x255 = (x_val << 8) - x_val;

    always_comb begin
        num_next  = x255;
        div_next  = DIV_W'(d_m) << 1;
        chan_next = CH_ALL;
        unique case (a_kind_reg)
            KIND_GRAY: begin
                if (!d_pos || !n_pos) begin
                    num_next = '0;
                    div_next = DIV_W'(1);
                end else if (n_ge_d) begin
                    num_next = NUM_W'(255);
                    div_next = DIV_W'(1);
                end else begin
                    // rounded: (510n + d) / 2d
                    num_next = (x255 << 1) + NUM_W'(d_m);
                end
            end
            KIND_BLUE: begin
                chan_next = CH_BLUE;
                if (!d_pos || !n_pos) begin
                    num_next = '0;
                    div_next = DIV_W'(1);
                end else begin
                    div_next = DIV_W'(d_m);
                end
            end
            KIND_GREEN: begin
                chan_next = CH_GREEN;
            end
            KIND_BROWN: begin
                chan_next = CH_BROWN;
                div_next  = (DIV_W'(d_m) << 3) + (DIV_W'(d_m) << 1);
            end
            KIND_TOP: begin
                if (!d_pos) begin
                    num_next = NUM_W'(255);
                    div_next = DIV_W'(1);
                end
            end
            default: begin
                num_next = '0;
                div_next = DIV_W'(1);
            end
        endcase
    end

    assign b_ready = !b_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready && a_valid_reg) begin
            num_reg  <= num_next;
            div_reg  <= div_next;
            chan_reg <= chan_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_chan  = chan_reg;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (div_reg != '0))
        else $error("divisor handed to the divider chain is zero");

endmodule

FILE: hdl/ecr_div_cell.sv
// one restoring division cell: produces one quotient bit per item
`timescale 1ns / 1ps

module ecr_div_cell #(
    parameter int NUM_W = 29,
    parameter int DIV_W = 21,
    parameter int SHIFT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [NUM_W-1:0]              in_rem,
    input  logic [DIV_W-1:0]              in_div,
    input  logic [ecr_pkg::QUOT_W-1:0]    in_quot,
    input  ecr_pkg::chan_t                in_chan,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NUM_W-1:0]              out_rem,
    output logic [DIV_W-1:0]              out_div,
    output logic [ecr_pkg::QUOT_W-1:0]    out_quot,
    output ecr_pkg::chan_t                out_chan
);
    import ecr_pkg::*;

    logic [NUM_W-1:0]  trial;
    logic              q_bit;
    logic [NUM_W-1:0]  rem_next;
    logic [QUOT_W-1:0] quot_next;

    logic              valid_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [QUOT_W-1:0] quot_reg;
    chan_t             chan_reg;

    assign trial     = NUM_W'(in_div) << SHIFT;
    assign q_bit     = in_rem >= trial;
    assign rem_next  = q_bit ? (in_rem - trial) : in_rem;
    assign quot_next = {in_quot[QUOT_W-2:0], q_bit};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quot_reg <= quot_next;
            chan_reg <= in_chan;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quot  = quot_reg;
    assign out_chan  = chan_reg;

endmodule

FILE: hdl/ecr_out.sv
// saturation, channel spreading and the output register
`timescale 1ns / 1ps

module ecr_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ecr_pkg::QUOT_W-1:0]    in_quot,
    input  ecr_pkg::chan_t                in_chan,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ecr_pkg::LEVEL_W-1:0]   out_red,
    output logic [ecr_pkg::LEVEL_W-1:0]   out_green,
    output logic [ecr_pkg::LEVEL_W-1:0]   out_blue
);
    import ecr_pkg::*;

    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] red_next, green_next, blue_next;

    logic               valid_reg;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg;

    // overflow bit set means the quotient ran past 255
    assign level = in_quot[QUOT_W-1] ? '1 : in_quot[LEVEL_W-1:0];

    always_comb begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        case (in_chan)
            CH_ALL: begin
                red_next   = level;
                green_next = level;
                blue_next  = level;
            end
            CH_BLUE:  blue_next = level;
            CH_GREEN: green_next = level;
            CH_BROWN: begin
                red_next   = level;
                green_next = level >> 2;
                blue_next  = level >> 2;
            end
            default: begin
                red_next = '0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

FILE: hdl/elevation_color_ramp_core.sv
// top level: config registers, setup stages, divider cell chain, output stage
//
//  channel | valid / ready      | payload
//  --------+--------------------+--------------------------------------------
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//  input   | s_valid/s_ready    | s_elevation
//  output  | m_valid/m_ready    | m_red_level, m_green_level, m_blue_level
//
//  one item per clock sustained while the output is ready; the path is two setup stages,
//  nine division cells (one quotient bit each, top one flags overflow)
//  and the output register.
//  every stage has its own valid bit and loads when the next one is empty
//  or moving, so bubbles collapse and a stall only backs up full stages.
//  reset loads the register defaults and empties the pipeline.
`timescale 1ns / 1ps

module elevation_color_ramp_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ecr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_elevation,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ecr_pkg::LEVEL_W-1:0]         m_red_level,
    output logic [ecr_pkg::LEVEL_W-1:0]         m_green_level,
    output logic [ecr_pkg::LEVEL_W-1:0]         m_blue_level
);
    import ecr_pkg::*;

    localparam int NUM_W = SAMPLE_BITS + 13;
    localparam int DIV_W = SAMPLE_BITS + 5;
    localparam int NCELL = QUOT_W;

    localparam logic [SAMPLE_BITS-1:0] RST_MIN   = SAMPLE_BITS'(-500);
    localparam logic [SAMPLE_BITS-1:0] RST_MAX   = SAMPLE_BITS'(5000);
    localparam logic [SAMPLE_BITS-1:0] RST_GREEN = SAMPLE_BITS'(500);
    localparam logic [SAMPLE_BITS-1:0] RST_BROWN = SAMPLE_BITS'(2000);

    logic signed [SAMPLE_BITS-1:0] floor_elev_reg, peak_elev_reg;
    logic signed [SAMPLE_BITS-1:0] green_limit_reg, brown_limit_reg;
    logic                          color_mode_reg;

    logic [NCELL:0]    c_valid;
    logic [NCELL:0]    c_ready;
    logic [NUM_W-1:0]  c_rem  [0:NCELL];
    logic [DIV_W-1:0]  c_div  [0:NCELL];
    logic [QUOT_W-1:0] c_quot [0:NCELL];
    chan_t             c_chan [0:NCELL];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_elev_reg  <= RST_MIN;
            peak_elev_reg   <= RST_MAX;
            green_limit_reg <= RST_GREEN;
            brown_limit_reg <= RST_BROWN;
            color_mode_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FLOOR_ELEV:  floor_elev_reg  <= cfg_data;
                REG_PEAK_ELEV:   peak_elev_reg   <= cfg_data;
                REG_GREEN_LIMIT: green_limit_reg <= cfg_data;
                REG_BROWN_LIMIT: brown_limit_reg <= cfg_data;
                REG_COLOR_MODE:  color_mode_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ecr_prep #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .NUM_W      (NUM_W),
        .DIV_W      (DIV_W)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_elev    (s_elevation),
        .floor_elev (floor_elev_reg),
        .peak_elev  (peak_elev_reg),
        .green_limit(green_limit_reg),
        .brown_limit(brown_limit_reg),
        .color_mode (color_mode_reg),
        .out_valid  (c_valid[0]),
        .out_ready  (c_ready[0]),
        .out_num    (c_rem[0]),
        .out_div    (c_div[0]),
        .out_chan   (c_chan[0])
    );

    assign c_quot[0] = '0;

    // first cell tests the overflow bit, the rest build the level msb first
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        ecr_div_cell #(
            .NUM_W(NUM_W),
            .DIV_W(DIV_W),
            .SHIFT(NCELL - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (c_valid[i]),
            .in_ready (c_ready[i]),
            .in_rem   (c_rem[i]),
            .in_div   (c_div[i]),
            .in_quot  (c_quot[i]),
            .in_chan  (c_chan[i]),
            .out_valid(c_valid[i+1]),
            .out_ready(c_ready[i+1]),
            .out_rem  (c_rem[i+1]),
            .out_div  (c_div[i+1]),
            .out_quot (c_quot[i+1]),
            .out_chan (c_chan[i+1])
        );
    end

    ecr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (c_valid[NCELL]),
        .in_ready (c_ready[NCELL]),
        .in_quot  (c_quot[NCELL]),
        .in_chan  (c_chan[NCELL]),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_red  (m_red_level),
        .out_green(m_green_level),
        .out_blue (m_blue_level)
    );

    // without overflow the chain must leave a remainder below the divisor
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid[NCELL] && !c_quot[NCELL][QUOT_W-1])
            |-> (c_rem[NCELL] < NUM_W'(c_div[NCELL])))
        else $error("division chain left a remainder not below the divisor");

    // input can only back up when every stage is full and output is stalled
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&c_valid)))
        else $error("input stalled while the pipeline has room");

endmodule

FILE: verif/elevation_color_ramp_checker.sv
// checker for the elevation color ramp: tracks the config, predicts every pixel, compares results
`timescale 1ns / 1ps

module elevation_color_ramp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ecr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_elevation,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ecr_pkg::LEVEL_W-1:0]         m_red_level,
    input  logic [ecr_pkg::LEVEL_W-1:0]         m_green_level,
    input  logic [ecr_pkg::LEVEL_W-1:0]         m_blue_level,
    output int                                  fail_count,
    output int                                  pending_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] elevation;
        logic [ecr_pkg::LEVEL_W-1:0]   red;
        logic [ecr_pkg::LEVEL_W-1:0]   green;
        logic [ecr_pkg::LEVEL_W-1:0]   blue;
    } pixel_t;

    logic signed [SAMPLE_BITS-1:0] ramp_lo;
    logic signed [SAMPLE_BITS-1:0] ramp_hi;
    logic signed [SAMPLE_BITS-1:0] green_top;
    logic signed [SAMPLE_BITS-1:0] brown_top;
    logic                          ramp_colored;

    pixel_t pixel_q [$];
    int     fails = 0;

    function automatic logic [ecr_pkg::LEVEL_W-1:0] clamp_level(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[ecr_pkg::LEVEL_W-1:0];
    endfunction

    function automatic pixel_t shade_elevation(input logic signed [SAMPLE_BITS-1:0] elev);
        pixel_t                      px;
        longint                      h, lo, hi, gl, bl, num, den;
        logic [ecr_pkg::LEVEL_W-1:0] lvl;
        h  = elev;
        lo = ramp_lo;
        hi = ramp_hi;
        gl = green_top;
        bl = brown_top;
        px.elevation = elev;
        px.red       = '0;
        px.green     = '0;
        px.blue      = '0;
        if (!ramp_colored) begin
            num = h - lo;
            den = hi - lo;
            if (den <= 0 || num <= 0) begin
                lvl = '0;
            end else if (num >= den) begin
                lvl = 8'd255;
            end else begin
                // rounded quotient
                lvl = clamp_level((510 * num + den) / (2 * den));
            end
            px.red   = lvl;
            px.green = lvl;
            px.blue  = lvl;
        end else if (h < 0) begin
            num = h - lo;
            den = -lo;
            if (den > 0 && num > 0) begin
                px.blue = clamp_level((255 * num) / den);
            end
        end else if (h < gl) begin
            px.green = clamp_level((255 * (gl + h)) / (2 * gl));
        end else if (h < bl) begin
            num = h - gl;
            den = bl - gl;
            lvl = clamp_level((255 * (2 * den + 5 * num)) / (10 * den));
            px.red   = lvl;
            px.green = lvl >> 2;
            px.blue  = lvl >> 2;
        end else begin
            num = h - bl;
            den = hi - bl;
            if (den <= 0) begin
                lvl = 8'd255;
            end else begin
                lvl = clamp_level((255 * (den + num)) / (2 * den));
            end
            px.red   = lvl;
            px.green = lvl;
            px.blue  = lvl;
        end
        return px;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            ramp_lo      = -500;
            ramp_hi      = 5000;
            green_top    = 500;
            brown_top    = 2000;
            ramp_colored = 1'b1;
            pixel_q.delete();
        end else begin
            // retire the oldest item before queueing a new one
            if (m_valid && m_ready) begin
                got.elevation = '0;
                got.red       = m_red_level;
                got.green     = m_green_level;
                got.blue      = m_blue_level;
                if (pixel_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("unexpected pixel r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                            || got.blue !== want.blue) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display({"pixel mismatch h=%0d: want r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     want.elevation, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
            // an item accepted at this edge still sees the old registers
            if (s_valid && s_ready) begin
                pixel_q.push_back(shade_elevation(s_elevation));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ecr_pkg::REG_FLOOR_ELEV:  ramp_lo      = cfg_data;
                    ecr_pkg::REG_PEAK_ELEV:   ramp_hi      = cfg_data;
                    ecr_pkg::REG_GREEN_LIMIT: green_top    = cfg_data;
                    ecr_pkg::REG_BROWN_LIMIT: brown_top    = cfg_data;
                    ecr_pkg::REG_COLOR_MODE:  ramp_colored = cfg_data[0];
                    default: ;
                endcase
            end
        end
        pending_count <= pixel_q.size();
        fail_count    <= fails;
    end

endmodule

FILE: verif/elevation_color_ramp_core_tb.sv
// testbench top: drives config, elevation items and backpressure, gives the verdict
`timescale 1ns / 1ps

module elevation_color_ramp_core_tb;

    localparam int SAMPLE_BITS     = 16;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int PAUSE_PHASE     = 3;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 200000;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [ecr_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
    logic [SAMPLE_BITS-1:0]        cfg_data    = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    sample_t                       s_elevation = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [ecr_pkg::LEVEL_W-1:0]   m_red_level;
    logic [ecr_pkg::LEVEL_W-1:0]   m_green_level;
    logic [ecr_pkg::LEVEL_W-1:0]   m_blue_level;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    int send_idle_pct = 25;
    int stall_pct     = 25;
    int stall_left    = 0;

    // current ramp, used only to aim the random elevations
    sample_t ramp_lo = -500;
    sample_t ramp_hi = 5000;
    sample_t gl_view = 500;
    sample_t bl_view = 2000;

    elevation_color_ramp_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elevation  (s_elevation),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_level  (m_red_level),
        .m_green_level(m_green_level),
        .m_blue_level (m_blue_level)
    );

    elevation_color_ramp_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elevation  (s_elevation),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_level  (m_red_level),
        .m_green_level(m_green_level),
        .m_blue_level (m_blue_level),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side stalls in bursts of random length
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic apply_ramp(input sample_t lo, input sample_t hi, input sample_t gl,
                              input sample_t bl, input logic colored);
        logic [ecr_pkg::CFG_IDX_W-1:0] idx [6];
        logic [SAMPLE_BITS-1:0]        val [6];
        int                            n;
        idx[0] = ecr_pkg::REG_FLOOR_ELEV;  val[0] = lo;
        idx[1] = ecr_pkg::REG_PEAK_ELEV;   val[1] = hi;
        idx[2] = ecr_pkg::REG_GREEN_LIMIT; val[2] = gl;
        idx[3] = ecr_pkg::REG_BROWN_LIMIT; val[3] = bl;
        // upper bits of the mode word are junk and must be dropped
        idx[4] = ecr_pkg::REG_COLOR_MODE;
        val[4] = SAMPLE_BITS'(($urandom() << 1) | colored);
        n = 5;
        if ($urandom_range(1) == 1) begin
            // unmapped index goes last so a stray decode would corrupt the ramp
            idx[5] = ecr_pkg::CFG_IDX_W'($urandom_range(ecr_pkg::REG_COLOR_MODE + 1,
                                                        2**ecr_pkg::CFG_IDX_W - 1));
            val[5] = SAMPLE_BITS'($urandom());
            n = 6;
        end
        ramp_lo = lo;
        ramp_hi = hi;
        gl_view = gl;
        bl_view = bl;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_ramp(input int kind, input logic colored);
        sample_t lo, hi, gl, bl;
        sample_t corners [5];
        corners[0] = -32768;
        corners[1] = -1;
        corners[2] = 0;
        corners[3] = 1;
        corners[4] = 32767;
        if (kind == 0) begin
            // ordered limits around sea level
            lo = sample_t'(-longint'($urandom_range(1, 32768)));
            gl = sample_t'($urandom_range(1, 10000));
            bl = sample_t'(gl + $urandom_range(1, 10000));
            hi = sample_t'(bl + $urandom_range(1, 32767 - bl));
        end else if (kind == 1) begin
            lo = sample_t'($urandom());
            hi = sample_t'($urandom());
            gl = sample_t'($urandom());
            bl = sample_t'($urandom());
        end else begin
            lo = corners[$urandom_range(4)];
            hi = corners[$urandom_range(4)];
            gl = corners[$urandom_range(4)];
            bl = corners[$urandom_range(4)];
        end
        apply_ramp(lo, hi, gl, bl, colored);
    endtask

    function automatic sample_t pick_elevation();
        int      r;
        longint  lo, hi;
        sample_t anchor;
        r = $urandom_range(9);
        if (r < 4) begin
            return sample_t'($urandom());
        end else if (r < 7) begin
            case ($urandom_range(4))
                0:       anchor = ramp_lo;
                1:       anchor = ramp_hi;
                2:       anchor = gl_view;
                3:       anchor = bl_view;
                default: anchor = '0;
            endcase
            return sample_t'(anchor + $urandom_range(6) - 3);
        end
        lo = ramp_lo;
        hi = ramp_hi;
        if (lo < hi) begin
            return sample_t'(lo + $urandom_range(0, 32'(hi - lo)));
        end
        return sample_t'($urandom());
    endfunction

    task automatic send_elevation(input sample_t h);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_elevation <= h;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_pixels();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        sample_t band_points [12];
        sample_t gray_points [7];
        sample_t odd_points  [5];
        band_points = '{-32768, -501, -500, -1, 0, 1, 499, 500, 1999, 2000, 5000, 32767};
        gray_points = '{-32768, -500, -499, 2250, 4999, 5000, 32767};
        odd_points  = '{-5, -32768, 0, 250, 32767};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset ramp, every color band and its edges
        foreach (band_points[i]) send_elevation(band_points[i]);
        drain_pixels();

        apply_ramp(-500, 5000, 500, 2000, 1'b0);
        foreach (gray_points[i]) send_elevation(gray_points[i]);
        drain_pixels();

        // flat gray ramp
        apply_ramp(100, 100, -10, -20, 1'b0);
        send_elevation(100);
        send_elevation(32767);
        drain_pixels();

        // no blue band, collapsed top band
        apply_ramp(100, 50, 200, 300, 1'b1);
        foreach (odd_points[i]) send_elevation(odd_points[i]);
        drain_pixels();

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_ramp(p % 3, logic'(p % 2));
            if (p == RAND_PHASES - 1) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end else begin
                send_idle_pct = (p % 4) * 15;
                stall_pct     = ((p + 1) % 4) * 15;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == PAUSE_PHASE && i == ITEMS_PER_PHASE / 2) begin
                    // hold off until the pipeline is empty
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending_count != 0) @(posedge aclk);
                end
                send_elevation(pick_elevation());
            end
            drain_pixels();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ecr_pkg.sv
hdl/ecr_prep.sv
hdl/ecr_div_cell.sv
hdl/ecr_out.sv
hdl/elevation_color_ramp_core.sv
verif/elevation_color_ramp_checker.sv
verif/elevation_color_ramp_core_tb.sv
